@@ rtl/sapq_pkg.sv @@
// ----------------------------------------------------------------------------
// sapq_pkg: shared types and codes for the sorted priority queue
// Job record layout, operation and status codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int OCC_W = 5;

  typedef struct packed {
    logic [3:0]  priority_val;
    logic [15:0] sequence_val;
    logic [7:0]  source_val;
    logic [3:0]  run_time_val;
    logic [16:0] ident_val;
  } job_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;     // capture a result this cycle
    logic       insert;   // shift in the new job
    logic       pop;      // shift out the head
    logic [1:0] code;     // status for the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage

@@ rtl/sorted_array_priority_queue.sv @@
// The result of an accepted item is on the output register in the next cycle.
// Throughput: one item per cycle while results are taken; the entry row compares and shifts in parallel.
// An item is accepted while a result waits if that result is taken the same cycle.
// Reset: synchronous, clears the fill count and the output valid; entries are
// not cleared and are never read before being written.
// ----------------------------------------------------------------------------
// sorted_array_priority_queue: stable sorted job queue
// Inserts jobs in priority order or pops the smallest-priority job.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [3:0]  job_priority,
  input  logic [15:0] job_sequence,
  input  logic [7:0]  job_source,
  input  logic [3:0]  job_run_time,
  input  logic [16:0] job_ident,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  out_priority,
  output logic [15:0] out_sequence,
  output logic [7:0]  out_source,
  output logic [3:0]  out_run_time,
  output logic [16:0] out_ident,
  output logic [4:0]  occupancy,
  output logic        is_empty_now,
  output logic        is_full_now
);

  sapq_pkg::cmd_t  cmd;
  sapq_pkg::stat_t stat;
  sapq_pkg::job_t  new_job;
  sapq_pkg::job_t  out_job;

  assign new_job.priority_val = job_priority;
  assign new_job.sequence_val = job_sequence;
  assign new_job.source_val   = job_source;
  assign new_job.run_time_val = job_run_time;
  assign new_job.ident_val    = job_ident;

  assign out_priority = out_job.priority_val;
  assign out_sequence = out_job.sequence_val;
  assign out_source   = out_job.source_val;
  assign out_run_time = out_job.run_time_val;
  assign out_ident    = out_job.ident_val;

  sapq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sapq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .new_job      (new_job),
    .status       (status),
    .out_job      (out_job),
    .occupancy    (occupancy),
    .is_empty_now (is_empty_now),
    .is_full_now  (is_full_now)
  );

endmodule

@@ rtl/sapq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sapq_ctrl: queue controller
// Handshake state machine; decodes the operation against the fill status.
// ----------------------------------------------------------------------------
module sapq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            operation,
  output logic            out_valid,
  input  logic            out_ready,
  input  sapq_pkg::stat_t stat,
  output sapq_pkg::cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign in_ready  = (state == S_IDLE) || out_ready;
  assign out_valid = (state == S_HOLD);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (accept) state_next = S_HOLD;
        else if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.load   = accept;
    cmd.insert = 1'b0;
    cmd.pop    = 1'b0;
    cmd.code   = sapq_pkg::STATUS_DONE;
    if (operation == sapq_pkg::OP_INSERT) begin
      if (stat.full) cmd.code = sapq_pkg::STATUS_FULL;
      else cmd.insert = accept;
    end else begin
      if (stat.empty) cmd.code = sapq_pkg::STATUS_EMPTY;
      else cmd.pop = accept;
    end
  end

endmodule

@@ rtl/sapq_dp.sv @@
// ----------------------------------------------------------------------------
// sapq_dp: queue datapath
// Sorted row of job entries with parallel compare-and-shift, fill count and
// result register.
// ----------------------------------------------------------------------------
module sapq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sapq_pkg::cmd_t             cmd,
  output sapq_pkg::stat_t            stat,
  input  sapq_pkg::job_t             new_job,
  output logic [1:0]                 status,
  output sapq_pkg::job_t             out_job,
  output logic [sapq_pkg::OCC_W-1:0] occupancy,
  output logic                       is_empty_now,
  output logic                       is_full_now
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  sapq_pkg::job_t entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign stat.empty = (count == '0);
  assign stat.full  = (count >= DEPTH_C);

  // keep[i]: entry i is live and not above the new priority (a prefix, since sorted)
  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_row
      assign keep[gi] = (count > CW'(gi)) &&
                        (entry[gi].priority_val <= new_job.priority_val);

      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (!keep[gi]) begin
            if (gi == 0) begin
              entry[gi] <= new_job;
            end else if (keep[(gi == 0) ? 0 : gi-1]) begin
              entry[gi] <= new_job;
            end else begin
              entry[gi] <= entry[(gi == 0) ? 0 : gi-1];
            end
          end
        end else if (cmd.pop) begin
          if (gi < QUEUE_DEPTH-1) begin
            entry[gi] <= entry[(gi < QUEUE_DEPTH-1) ? gi+1 : gi];
          end
        end
      end
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (cmd.insert) count_next = count + CW'(1);
    else if (cmd.pop) count_next = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status       <= cmd.code;
      out_job      <= cmd.pop ? entry[0] : '0;
      occupancy    <= sapq_pkg::OCC_W'(count_next);
      is_empty_now <= (count_next == '0);
      is_full_now  <= (count_next >= DEPTH_C);
    end
  end

endmodule

@@ rtl/sapq_checker.sv @@
// ----------------------------------------------------------------------------
// sapq_checker: port-level checks for the sorted priority queue
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module sapq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [3:0]  out_priority,
  input logic [4:0]  occupancy,
  input logic        is_empty_now,
  input logic        is_full_now
);

  // every accepted item yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after accepted item");

  // a waiting result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(occupancy)))
    else $error("stalled result changed");

  // a rejected insert leaves the queue full
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == sapq_pkg::STATUS_FULL) |-> is_full_now)
    else $error("full reject without full flag");

  // a rejected pop leaves the queue empty and carries no job
  a_empty_reject: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == sapq_pkg::STATUS_EMPTY) |->
      (is_empty_now && occupancy == 5'd0 && out_priority == 4'd0))
    else $error("empty reject inconsistent");

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .out_priority (out_priority),
  .occupancy    (occupancy),
  .is_empty_now (is_empty_now),
  .is_full_now  (is_full_now)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_array_priority_queue
// A directed table of inserts and pops walks the queue from empty to full
// and partly back. Random blocks with varying insert bias follow. Both channels
// idle at random. Every result is compared field by field with a stable
// sorted-queue predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH         = 16;
  localparam int BLOCK_ITEMS   = 60;
  localparam int RANDOM_BLOCKS = 30;
  localparam int TAIL_CYCLES   = 8;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct {
    logic [1:0]                 status;
    sapq_pkg::job_t             job;
    logic [sapq_pkg::OCC_W-1:0] occ;
    logic                       empty;
    logic                       full;
  } pq_result_t;

  typedef struct {
    logic           op;
    sapq_pkg::job_t job;
    bit             typed;
    pq_result_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = sapq_pkg::OP_INSERT;
  logic [3:0]  job_priority = '0;
  logic [15:0] job_sequence = '0;
  logic [7:0]  job_source = '0;
  logic [3:0]  job_run_time = '0;
  logic [16:0] job_ident = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [3:0]  out_priority;
  logic [15:0] out_sequence;
  logic [7:0]  out_source;
  logic [3:0]  out_run_time;
  logic [16:0] out_ident;
  logic [4:0]  occupancy;
  logic        is_empty_now;
  logic        is_full_now;

  // predictor state
  sapq_pkg::job_t job_store [DEPTH];
  int             job_count = 0;

  pq_result_t pending_results [$];
  stim_row_t  directed_rows [$];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         no_idle = 1'b0;

  sorted_array_priority_queue #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .job_priority (job_priority),
    .job_sequence (job_sequence),
    .job_source   (job_source),
    .job_run_time (job_run_time),
    .job_ident    (job_ident),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_priority (out_priority),
    .out_sequence (out_sequence),
    .out_source   (out_source),
    .out_run_time (out_run_time),
    .out_ident    (out_ident),
    .occupancy    (occupancy),
    .is_empty_now (is_empty_now),
    .is_full_now  (is_full_now)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Stable insert: new job goes behind every stored job of equal or lower value.
  function automatic pq_result_t predict_queue_op(logic op, sapq_pkg::job_t job);
    pq_result_t res;
    int         pos;
    res.status = sapq_pkg::STATUS_DONE;
    res.job    = '0;
    if (op == sapq_pkg::OP_INSERT) begin
      if (job_count >= DEPTH) begin
        res.status = sapq_pkg::STATUS_FULL;
      end else begin
        pos = job_count;
        while (pos > 0 && job_store[pos-1].priority_val > job.priority_val) begin
          job_store[pos] = job_store[pos-1];
          pos--;
        end
        job_store[pos] = job;
        job_count++;
      end
    end else begin
      if (job_count == 0) begin
        res.status = sapq_pkg::STATUS_EMPTY;
      end else begin
        res.job = job_store[0];
        for (int i = 0; i + 1 < job_count; i++) job_store[i] = job_store[i+1];
        job_count--;
      end
    end
    res.occ   = sapq_pkg::OCC_W'(job_count);
    res.empty = (job_count == 0);
    res.full  = (job_count >= DEPTH);
    return res;
  endfunction

  function automatic pq_result_t typed_result(logic [1:0] code, int occ);
    pq_result_t res;
    res.status = code;
    res.job    = '0;
    res.occ    = sapq_pkg::OCC_W'(occ);
    res.empty  = (occ == 0);
    res.full   = (occ >= DEPTH);
    return res;
  endfunction

  function automatic void add_row(logic op, logic [3:0] prio, logic [15:0] seq,
                                  logic [7:0] src, logic [3:0] rt, logic [16:0] id,
                                  bit typed, pq_result_t want);
    stim_row_t row;
    row.op                = op;
    row.job.priority_val  = prio;
    row.job.sequence_val  = seq;
    row.job.source_val    = src;
    row.job.run_time_val  = rt;
    row.job.ident_val     = id;
    row.typed             = typed;
    row.want              = want;
    directed_rows.push_back(row);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report(string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic send_item(logic op, sapq_pkg::job_t job, bit typed, pq_result_t want);
    pq_result_t res;
    in_valid     <= 1'b1;
    operation    <= op;
    job_priority <= job.priority_val;
    job_sequence <= job.sequence_val;
    job_source   <= job.source_val;
    job_run_time <= job.run_time_val;
    job_ident    <= job.ident_val;
    do @(posedge clk); while (!in_ready);
    res = predict_queue_op(op, job);
    pending_results.push_back(typed ? want : res);
  endtask

  task automatic idle_gap();
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_results
    pq_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("result with no item waiting");
      end else begin
        want = pending_results.pop_front();
        check_field("status", status, want.status);
        check_field("out_priority", out_priority, want.job.priority_val);
        check_field("out_sequence", out_sequence, want.job.sequence_val);
        check_field("out_source", out_source, want.job.source_val);
        check_field("out_run_time", out_run_time, want.job.run_time_val);
        check_field("out_ident", out_ident, want.job.ident_val);
        check_field("occupancy", occupancy, want.occ);
        check_field("is_empty_now", is_empty_now, want.empty);
        check_field("is_full_now", is_full_now, want.full);
      end
    end
  end

  // result side back-pressure
  initial begin : ready_driver
    int   hold;
    logic ready_val;
    hold      = 0;
    ready_val = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        if (no_idle || $urandom_range(0, 99) < 65) begin
          ready_val = 1'b1;
          hold      = $urandom_range(1, 20);
        end else begin
          ready_val = 1'b0;
          hold      = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
        end
      end
      hold--;
      out_ready <= ready_val;
    end
  end

  initial begin : stimulus
    pq_result_t     none;
    sapq_pkg::job_t job;
    logic           op;
    int             ins_bias;
    bit             narrow;

    none = typed_result(sapq_pkg::STATUS_DONE, 0);

    // pop on empty, then fill with extremes and ties, overfill, partial drain
    add_row(sapq_pkg::OP_POP,    4'd0,  16'h1234, 8'h56, 4'h7, 17'h0abcd, 1'b1,
            typed_result(sapq_pkg::STATUS_EMPTY, 0));
    add_row(sapq_pkg::OP_INSERT, 4'd15, 16'hffff, 8'hff, 4'hf, 17'h1ffff, 1'b1,
            typed_result(sapq_pkg::STATUS_DONE, 1));
    add_row(sapq_pkg::OP_INSERT, 4'd0,  16'h0000, 8'h00, 4'h0, 17'h00000, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd7,  16'h0001, 8'h11, 4'h1, 17'h10001, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd7,  16'h0002, 8'h22, 4'h2, 17'h10002, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd7,  16'h0003, 8'h33, 4'h3, 17'h10003, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd0,  16'h0004, 8'h44, 4'h4, 17'h00004, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd15, 16'h0005, 8'h55, 4'h5, 17'h00005, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd3,  16'h8006, 8'h66, 4'h6, 17'h0aaaa, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd12, 16'h4007, 8'h77, 4'h8, 17'h15555, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd1,  16'h2008, 8'h88, 4'h9, 17'h00008, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd7,  16'h1009, 8'h99, 4'ha, 17'h10009, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd14, 16'h000a, 8'haa, 4'hb, 17'h0000a, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd2,  16'h000b, 8'hbb, 4'hc, 17'h0000b, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd9,  16'h000c, 8'hcc, 4'hd, 17'h0000c, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd0,  16'h000d, 8'hdd, 4'he, 17'h0000d, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd5,  16'h000e, 8'hee, 4'hf, 17'h0000e, 1'b0, none);
    add_row(sapq_pkg::OP_INSERT, 4'd0,  16'hdead, 8'h5a, 4'h3, 17'h1beef, 1'b1,
            typed_result(sapq_pkg::STATUS_FULL, DEPTH));
    repeat (8) add_row(sapq_pkg::OP_POP, 4'd15, 16'hffff, 8'hff, 4'hf, 17'h1ffff,
                       1'b0, none);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].op, directed_rows[k].job,
                directed_rows[k].typed, directed_rows[k].want);
      idle_gap();
    end

    // blocks swing the fill level between empty and full
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      case ($urandom_range(0, 2))
        0: ins_bias = 85;
        1: ins_bias = 50;
        default: ins_bias = 15;
      endcase
      narrow  = ($urandom_range(0, 1) == 1);
      no_idle = ($urandom_range(0, 4) == 0);
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        op = ($urandom_range(0, 99) < ins_bias) ? sapq_pkg::OP_INSERT : sapq_pkg::OP_POP;
        job.priority_val = narrow ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        job.sequence_val = 16'($urandom);
        job.source_val   = 8'($urandom);
        job.run_time_val = 4'($urandom);
        job.ident_val    = 17'($urandom);
        send_item(op, job, 1'b0, none);
        idle_gap();
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
